### hw/rtl/htb_pkg.sv
// Package for the hex text to bytes parser.
// Holds the parse phase type, character constants and character class functions.
// Depends on nothing.
`timescale 1ns / 1ps

package htb_pkg;

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_PREFIX,
      PH_FRAME,
      PH_HEX
   } phase_type;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF_HI = 8'h66;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_B     = 8'h42;
   localparam logic [7:0] CHAR_U     = 8'h55;
   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic [7:0] CHAR_R     = 8'h52;

   localparam logic [2:0] PREFIX_LEN = 3'd7;
   localparam logic [3:0] NIBBLE_B   = 4'hB;

   function automatic logic is_white(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) || (c == CHAR_CR);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_0) && (c <= CHAR_9);
   endfunction

   // Returns {valid, nibble}.
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if ((c >= CHAR_0) && (c <= CHAR_9)) begin
         d = c - CHAR_0;
         return {1'b1, d[3:0]};
      end else if ((c >= CHAR_LA) && (c <= CHAR_LF_HI)) begin
         d = c - CHAR_LA + 8'd10;
         return {1'b1, d[3:0]};
      end else if ((c >= CHAR_UA) && (c <= CHAR_UF)) begin
         d = c - CHAR_UA + 8'd10;
         return {1'b1, d[3:0]};
      end
      return 5'b0_0000;
   endfunction

   function automatic logic [7:0] prefix_char(input logic [2:0] pos);
      logic [7:0] c;
      unique case (pos)
         3'd0: c = CHAR_B;
         3'd1: c = CHAR_U;
         3'd2: c = CHAR_UF;
         3'd3: c = CHAR_UF;
         3'd4: c = CHAR_E;
         3'd5: c = CHAR_R;
         3'd6: c = CHAR_SPACE;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

### hw/rtl/hex_text_to_bytes_parser.sv
// Top level of the hex text to bytes parser: one character in, one result out.
// Depends on htb_pkg for the phase type and character classes.
//
//  Channel | Direction | Ports
//  req     | in        | req_valid, req_stall, req_char_code, req_end_of_text
//  rsp     | out       | rsp_valid, rsp_stall, rsp_byte_* , rsp_text_done, rsp_failed
//  csr     | in        | csr_wr_en, csr_wr_data (capacity)
//
// One transaction per cycle when not stalled; results appear in the next cycle.
// The per-character state update and the result register are updated in the same cycle.
// Synchronous active-high reset clears the parse state and sets capacity to 65535.
// A stalled result holds the output register and stalls the request side.
`timescale 1ns / 1ps

module hex_text_to_bytes_parser #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_byte_valid,
   output logic [7:0]  rsp_byte_value,
   output logic [15:0] rsp_byte_index,
   output logic        rsp_text_done,
   output logic        rsp_failed,
   output logic [15:0] rsp_byte_total,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import htb_pkg::*;

   localparam int WIDE = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   logic [15:0]           capacity_ff;
   phase_type             phase_ff, phase_in;
   logic [2:0]            matched_ff, matched_in;
   logic [3:0]            held_ff, held_in;
   logic                  pending_ff, pending_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  error_ff, error_in;

   logic                  rsp_valid_ff;
   logic                  byte_valid_ff, byte_valid_in;
   logic [7:0]            byte_value_ff, byte_value_in;
   logic [15:0]           byte_index_ff, byte_index_in;
   logic                  text_done_ff;
   logic                  failed_ff;
   logic [15:0]           byte_total_ff, byte_total_in;

   logic                  accept;
   logic                  do_hex;
   logic                  hex_pend;
   logic [3:0]            hex_held;
   logic [4:0]            nib;
   logic                  full;
   logic                  over;
   logic [WIDE-1:0]       count_wide;
   logic [WIDE-1:0]       cap_wide;
   logic [WIDE-1:0]       total_wide;
   logic [7:0]            c;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign c         = req_char_code;
   assign nib       = hex_nibble(c);
   assign count_wide = WIDE'(count_ff);
   assign cap_wide   = WIDE'(capacity_ff);
   assign full      = &count_ff;
   assign over      = count_wide >= cap_wide;
   assign total_wide = WIDE'(count_in);
   assign byte_total_in = total_wide[15:0];

   always_comb begin
      phase_in      = phase_ff;
      matched_in    = matched_ff;
      error_in      = error_ff;
      count_in      = count_ff;
      do_hex        = 1'b0;
      hex_pend      = pending_ff;
      hex_held      = held_ff;
      byte_valid_in = 1'b0;
      byte_value_in = 8'h00;
      byte_index_in = 16'h0000;

      if (!error_ff) begin
         unique case (phase_ff)
            PH_LEAD: begin
               if (is_white(c)) begin
               end else if (c == CHAR_B) begin
                  phase_in   = PH_PREFIX;
                  matched_in = 3'd1;
               end else begin
                  phase_in = PH_HEX;
                  do_hex   = 1'b1;
               end
            end
            PH_PREFIX: begin
               if ((matched_ff < PREFIX_LEN) && (c == prefix_char(matched_ff))) begin
                  matched_in = matched_ff + 3'd1;
               end else if (matched_ff >= PREFIX_LEN) begin
                  matched_in = 3'd0;
                  if (is_digit(c)) begin
                     phase_in = PH_FRAME;
                  end else begin
                     phase_in = PH_HEX;
                     do_hex   = 1'b1;
                  end
               end else if (matched_ff == 3'd1) begin
                  phase_in   = PH_HEX;
                  matched_in = 3'd0;
                  hex_pend   = 1'b1;
                  hex_held   = NIBBLE_B;
                  do_hex     = 1'b1;
               end else begin
                  error_in = 1'b1;
               end
            end
            PH_FRAME: begin
               if (!is_digit(c)) begin
                  phase_in = PH_HEX;
                  do_hex   = 1'b1;
               end
            end
            PH_HEX: begin
               do_hex = 1'b1;
            end
            default: begin
               do_hex = 1'b1;
            end
         endcase
      end

      held_in    = hex_held;
      pending_in = hex_pend;
      if (do_hex) begin
         if (!hex_pend) begin
            if (is_white(c)) begin
            end else if (!nib[4]) begin
               error_in = 1'b1;
            end else begin
               held_in    = nib[3:0];
               pending_in = 1'b1;
            end
         end else if (!nib[4]) begin
            error_in = 1'b1;
         end else begin
            pending_in = 1'b0;
            held_in    = 4'h0;
            if (full || over) begin
               error_in = 1'b1;
            end else begin
               byte_valid_in = 1'b1;
               byte_value_in = {hex_held, nib[3:0]};
               byte_index_in = count_wide[15:0];
               count_in      = count_ff + COUNT_BITS'(1);
            end
         end
      end

      if (req_end_of_text && !error_in && (pending_in || (phase_in == PH_PREFIX))) begin
         error_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= 16'hFFFF;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LEAD;
         matched_ff <= 3'd0;
         held_ff    <= 4'h0;
         pending_ff <= 1'b0;
         count_ff   <= '0;
         error_ff   <= 1'b0;
      end else if (accept) begin
         if (req_end_of_text) begin
            phase_ff   <= PH_LEAD;
            matched_ff <= 3'd0;
            held_ff    <= 4'h0;
            pending_ff <= 1'b0;
            count_ff   <= '0;
            error_ff   <= 1'b0;
         end else begin
            phase_ff   <= phase_in;
            matched_ff <= matched_in;
            held_ff    <= held_in;
            pending_ff <= pending_in;
            count_ff   <= count_in;
            error_ff   <= error_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_valid_ff <= byte_valid_in;
         byte_value_ff <= byte_value_in;
         byte_index_ff <= byte_index_in;
         text_done_ff  <= req_end_of_text;
         failed_ff     <= error_in;
         byte_total_ff <= byte_total_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_byte_value = byte_value_ff;
   assign rsp_byte_index = byte_index_ff;
   assign rsp_text_done  = text_done_ff;
   assign rsp_failed     = failed_ff;
   assign rsp_byte_total = byte_total_ff;

   // A decoded byte is never reported together with an error.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_byte_valid) |-> !rsp_failed)
      else $error("byte reported on a failed text");

   // The running total counts the byte just reported.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_byte_valid) |-> (rsp_byte_total == 16'(rsp_byte_index + 16'd1)))
      else $error("byte total out of step with byte index");

   // The final character of a text returns the parse state to its start.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_text) |=>
         ((count_ff == '0) && (phase_ff == PH_LEAD) && !error_ff && !pending_ff))
      else $error("parse state not cleared at end of text");

   // A new transaction is only taken once the previous result has left or is leaving.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !accept)
      else $error("result register overwritten while stalled");

endmodule

### tb/hex_text_checker.sv
// Checker for the hex text to bytes parser: watches the request, result and
// register ports, predicts each result and compares it field by field.
// Depends on htb_pkg for the phase type and the character constants.
`timescale 1ns / 1ps

module hex_text_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_text,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_byte_valid,
   input  logic [7:0]  rsp_byte_value,
   input  logic [15:0] rsp_byte_index,
   input  logic        rsp_text_done,
   input  logic        rsp_failed,
   input  logic [15:0] rsp_byte_total,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          mismatch_count,
   output int          pending_count
);
   import htb_pkg::*;

   typedef struct packed {
      logic        byte_valid;
      logic [7:0]  byte_value;
      logic [15:0] byte_index;
      logic        text_done;
      logic        failed;
      logic [15:0] byte_total;
   } decode_result_type;

   localparam logic [55:0] PREFIX_WORD = "BUFFER ";
   localparam int PRINT_LIMIT = 100;

   phase_type         parse_phase;
   logic [2:0]        prefix_len;
   logic [3:0]        held_nibble;
   logic              nibble_held;
   logic [15:0]       byte_count;
   logic              sticky_error;
   logic [15:0]       capacity;
   int                response_count;
   decode_result_type expected_q[$];

   initial begin
      mismatch_count = 0;
      pending_count = 0;
      response_count = 0;
   end

   function automatic logic is_blank(input logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR;
   endfunction

   function automatic logic [4:0] hex_value(input logic [7:0] c);
      if (c >= CHAR_0 && c <= CHAR_9) return {1'b1, c[3:0]};
      if ((c >= CHAR_LA && c <= CHAR_LF_HI) || (c >= CHAR_UA && c <= CHAR_UF))
         return {1'b1, c[3:0] + 4'd9};
      return 5'd0;
   endfunction

   task automatic clear_text();
      parse_phase = PH_LEAD;
      prefix_len = '0;
      held_nibble = '0;
      nibble_held = 1'b0;
      byte_count = '0;
      sticky_error = 1'b0;
   endtask

   task automatic push_byte(input logic [7:0] value, inout decode_result_type r);
      if (byte_count >= capacity) begin
         sticky_error = 1'b1;
         return;
      end
      r.byte_valid = 1'b1;
      r.byte_value = value;
      r.byte_index = byte_count;
      byte_count = byte_count + 16'd1;
   endtask

   task automatic hex_step(input logic [7:0] c, inout decode_result_type r);
      logic [4:0] n;
      n = hex_value(c);
      if (!nibble_held) begin
         if (is_blank(c)) return;
         if (!n[4]) begin
            sticky_error = 1'b1;
            return;
         end
         held_nibble = n[3:0];
         nibble_held = 1'b1;
         return;
      end
      if (!n[4]) begin
         sticky_error = 1'b1;
         return;
      end
      nibble_held = 1'b0;
      push_byte({held_nibble, n[3:0]}, r);
      held_nibble = '0;
   endtask

   task automatic frame_step(input logic [7:0] c, inout decode_result_type r);
      if (c >= CHAR_0 && c <= CHAR_9) return;
      parse_phase = PH_HEX;
      hex_step(c, r);
   endtask

   task automatic predict_char(input logic [7:0] c, input logic eot,
                               output decode_result_type r);
      r = '0;
      r.text_done = eot;
      if (!sticky_error) begin
         case (parse_phase)
            PH_LEAD: begin
               if (!is_blank(c)) begin
                  if (c == CHAR_B) begin
                     parse_phase = PH_PREFIX;
                     prefix_len = 3'd1;
                  end else begin
                     parse_phase = PH_HEX;
                     hex_step(c, r);
                  end
               end
            end
            PH_PREFIX: begin
               if (prefix_len < PREFIX_LEN &&
                   c == PREFIX_WORD[8 * (6 - int'(prefix_len)) +: 8]) begin
                  prefix_len = prefix_len + 3'd1;
               end else if (prefix_len == PREFIX_LEN) begin
                  parse_phase = PH_FRAME;
                  prefix_len = '0;
                  frame_step(c, r);
               end else if (prefix_len == 3'd1) begin
                  parse_phase = PH_HEX;
                  prefix_len = '0;
                  held_nibble = NIBBLE_B;
                  nibble_held = 1'b1;
                  hex_step(c, r);
               end else begin
                  sticky_error = 1'b1;
               end
            end
            PH_FRAME: frame_step(c, r);
            PH_HEX: hex_step(c, r);
         endcase
      end
      if (eot && !sticky_error && (nibble_held || parse_phase == PH_PREFIX))
         sticky_error = 1'b1;
      r.failed = sticky_error;
      r.byte_total = byte_count;
      if (eot) clear_text();
   endtask

   task automatic note_mismatch(input string msg);
      mismatch_count = mismatch_count + 1;
      if (mismatch_count <= PRINT_LIMIT)
         $display("MISMATCH at result %0d: %s", response_count, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         note_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   always @(posedge clock) begin : watch
      decode_result_type want;
      decode_result_type got;
      if (reset) begin
         clear_text();
         capacity = 16'hFFFF;
         expected_q.delete();
      end else begin
         if (csr_wr_en) capacity = csr_wr_data;
         if (req_valid && !req_stall) begin
            predict_char(req_char_code, req_end_of_text, want);
            expected_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_byte_valid, rsp_byte_value, rsp_byte_index,
                   rsp_text_done, rsp_failed, rsp_byte_total};
            if (expected_q.size() == 0) begin
               note_mismatch("result transaction with no character outstanding");
            end else begin
               want = expected_q.pop_front();
               check_field("byte_valid", got.byte_valid, want.byte_valid);
               check_field("byte_value", got.byte_value, want.byte_value);
               check_field("byte_index", got.byte_index, want.byte_index);
               check_field("text_done", got.text_done, want.text_done);
               check_field("failed", got.failed, want.failed);
               check_field("byte_total", got.byte_total, want.byte_total);
            end
            response_count = response_count + 1;
         end
      end
      pending_count <= expected_q.size();
   end

endmodule

### tb/tb.sv
// Top of the hex text to bytes parser testbench: clock, reset, register writes
// and character stimulus in several phases of idles and stalls, and the final verdict.
// Depends on htb_pkg, hex_text_to_bytes_parser and hex_text_checker.
`timescale 1ns / 1ps

module tb;
   import htb_pkg::*;

   localparam int PHASE_COUNT = 6;
   localparam int PHASE_ITEMS = 150;
   localparam int CYCLE_LIMIT = 300000;
   localparam logic [8*22-1:0] HEX_DIGITS = "0123456789abcdefABCDEF";
   localparam logic [31:0] BLANKS = {CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_CR};
   localparam logic [55:0] PREFIX_WORD = "BUFFER ";

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code = 8'h00;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_byte_valid;
   logic [7:0]  rsp_byte_value;
   logic [15:0] rsp_byte_index;
   logic        rsp_text_done;
   logic        rsp_failed;
   logic [15:0] rsp_byte_total;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'h0000;
   int          mismatch_count;
   int          pending_count;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          cycle_count = 0;
   int          phase_items = 0;
   logic [7:0]  text_buf[$];

   hex_text_to_bytes_parser dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_code(req_char_code),
      .req_end_of_text(req_end_of_text),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_byte_value(rsp_byte_value),
      .rsp_byte_index(rsp_byte_index),
      .rsp_text_done(rsp_text_done),
      .rsp_failed(rsp_failed),
      .rsp_byte_total(rsp_byte_total),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   hex_text_checker scoreboard (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_code(req_char_code),
      .req_end_of_text(req_end_of_text),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_byte_value(rsp_byte_value),
      .rsp_byte_index(rsp_byte_index),
      .rsp_text_done(rsp_text_done),
      .rsp_failed(rsp_failed),
      .rsp_byte_total(rsp_byte_total),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .mismatch_count(mismatch_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [7:0] random_hex();
      return HEX_DIGITS[8 * $urandom_range(21) +: 8];
   endfunction

   function automatic logic [7:0] random_blank();
      return BLANKS[8 * $urandom_range(3) +: 8];
   endfunction

   task automatic send_char(input logic [7:0] c, input logic eot);
      logic go;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= c;
      req_end_of_text <= eot;
      do begin
         @(negedge clock);
         go = !req_stall;
         @(posedge clock);
      end while (!go);
      phase_items = phase_items + 1;
   endtask

   task automatic send_text();
      foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
   endtask

   task automatic load_string(input string s);
      text_buf.delete();
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endtask

   task automatic write_capacity(input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (3) @(posedge clock);
   endtask

   // Mostly well-formed texts, some with one character damaged or cut short,
   // and some pure noise over the full character range.
   task automatic build_text();
      int kind;
      int cut;
      text_buf.delete();
      kind = $urandom_range(99);
      if (kind < 15) begin
         repeat ($urandom_range(6, 1)) text_buf.push_back(8'($urandom_range(255)));
         return;
      end
      repeat ($urandom_range(2)) text_buf.push_back(random_blank());
      if ($urandom_range(1)) begin
         for (int i = 6; i >= 0; i--) text_buf.push_back(PREFIX_WORD[8 * i +: 8]);
         repeat ($urandom_range(3)) text_buf.push_back(CHAR_0 + 8'($urandom_range(9)));
         text_buf.push_back(random_blank());
      end
      repeat ($urandom_range(8, 1)) begin
         if ($urandom_range(3) == 0) text_buf.push_back(random_blank());
         text_buf.push_back(random_hex());
         text_buf.push_back(random_hex());
      end
      if ($urandom_range(3) == 0) text_buf.push_back(random_blank());
      if (kind < 30) begin
         cut = $urandom_range(text_buf.size() - 1);
         case ($urandom_range(2))
            0: text_buf[cut] = 8'($urandom_range(255));
            1: while (text_buf.size() > cut + 1) void'(text_buf.pop_back());
            default: text_buf[cut] = random_blank();
         endcase
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 83; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 83; end
            3: begin send_idle_pct = 27; stall_pct = 27; end
            4: begin send_idle_pct = 0;  stall_pct = 83; end
            default: begin send_idle_pct = 27; stall_pct = 27; end
         endcase
         case (p)
            1: write_capacity(16'h0000);
            2: write_capacity(16'($urandom_range(6, 1)));
            3: write_capacity(16'hFFFF);
            4: write_capacity(16'($urandom_range(12, 2)));
            5: write_capacity(16'h0001);
            default: ;
         endcase
         phase_items = 0;
         if (p == 0) begin
            load_string(" \t\n\015B3");
            send_text();
            load_string("BUFFER 9aF");
            send_text();
            load_string("BUX");
            send_text();
            load_string("BUFFER ");
            send_text();
            load_string("7");
            send_text();
            load_string("1 2");
            send_text();
            load_string("4");
            text_buf.push_back(8'h00);
            send_text();
            text_buf.delete();
            text_buf.push_back(8'hFF);
            send_text();
            phase_items = 0;
         end
         while (phase_items < PHASE_ITEMS) begin
            build_text();
            send_text();
         end
         wait_drain();
      end
      if (mismatch_count == 0 && pending_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
